// File: sv/qase_pkg.sv
// Package for the quadrature angle and speed estimator.
// Widths, filter coefficients, register indexes and the control word between
// the top level and the speed datapath. No dependencies.
package qase_pkg;

  localparam int unsigned CNT_W      = 16;  // encoder count and angle width
  localparam int unsigned STEP_W     = $clog2(CNT_W);
  localparam int unsigned PP_W       = 7;
  localparam int unsigned RPM_W      = 16;
  localparam int unsigned SF_W       = 32;  // Q16.16 filter state
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned CPR_DEF   = 4000;
  localparam int unsigned SCALE_DEF = 15;

  // 0.6 and 0.4 in Q16
  localparam logic [CNT_W-1:0] COEF_OLD = 16'd39322;
  localparam logic [CNT_W-1:0] COEF_NEW = 16'd26214;

  localparam logic signed [RPM_W-1:0] RPM_MAX = 16'sh7fff;
  localparam logic signed [RPM_W-1:0] RPM_MIN = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS  = 2'd2;

  localparam logic [PP_W-1:0] POLE_PAIRS_RST = 7'd1;

  typedef struct packed {
    logic load;      // word accepted, capture tick difference
    logic mul_step;  // one bit of the rpm scale multiply
    logic sat;       // clamp rpm, prime the filter
    logic iir_step;  // one coefficient bit of the filter
    logic commit;    // write back the filter state
  } qase_ctrl_t;

endpackage

// File: sv/qase_if.sv
// Stream interfaces for input samples and angle/speed results.
// Depends on qase_pkg for field widths.
interface qase_in_if;
  import qase_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [CNT_W-1:0] count;
  modport source (output valid, req_type, count, input ready);
  modport sink   (input valid, req_type, count, output ready);
endinterface

interface qase_out_if;
  import qase_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        mech_pos;
  logic [CNT_W-1:0]        elec_pos;
  logic signed [RPM_W-1:0] rotor_rpm;
  modport source (output valid, mech_pos, elec_pos, rotor_rpm, input ready);
  modport sink   (input valid, mech_pos, elec_pos, rotor_rpm, output ready);
endinterface

// File: sv/qase_speed.sv
// Speed path: tick count difference with wrap fix, bit-serial rpm scaling,
// bit-serial 0.6/0.4 IIR in Q16.16. Depends on qase_pkg.
module qase_speed #(
  parameter int unsigned COUNTS_PER_REV = qase_pkg::CPR_DEF,
  parameter int unsigned TICK_RPM_SCALE = qase_pkg::SCALE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qase_pkg::qase_ctrl_t             ctrl_i,
  input  logic [qase_pkg::STEP_W-1:0]      step_i,
  input  logic                             req_i,
  input  logic [qase_pkg::CNT_W-1:0]       count_i,
  output logic signed [qase_pkg::RPM_W-1:0] rotor_rpm_o
);
  import qase_pkg::*;

  localparam logic signed [CNT_W:0] CPR_S  = (CNT_W+1)'(COUNTS_PER_REV);
  localparam logic signed [CNT_W:0] HALF_S = (CNT_W+1)'(COUNTS_PER_REV / 2);
  localparam logic [CNT_W-1:0]      SCALE_V = CNT_W'(TICK_RPM_SCALE);
  localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(CNT_W - 1);

  logic [CNT_W-1:0]         last_q;
  logic signed [SF_W-1:0]   sf_q;
  logic                     req_q;
  logic [CNT_W-1:0]         mag_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic signed [SF_W:0]     acc_q;
  logic signed [SF_W-1:0]   p2_q;
  logic signed [SF_W-1:0]   rsh_q;

  logic signed [CNT_W:0]    diff_raw;
  logic signed [CNT_W:0]    diff_fix;
  logic [STEP_W-1:0]        scale_idx;
  logic signed [RPM_W-1:0]  rpm_v;
  logic signed [SF_W:0]     acc_sum;

  always_comb begin
    diff_raw = $signed({1'b0, count_i}) - $signed({1'b0, last_q});
    if (diff_raw < -HALF_S) begin
      diff_fix = diff_raw + CPR_S;
    end else if (diff_raw > HALF_S) begin
      diff_fix = diff_raw - CPR_S;
    end else begin
      diff_fix = diff_raw;
    end
  end

  assign scale_idx = STEP_LAST - step_i;

  always_comb begin
    if (neg_q) begin
      rpm_v = (prod_q > PROD_W'(32768)) ? RPM_MIN : -$signed(prod_q[RPM_W-1:0]);
    end else begin
      rpm_v = (prod_q[PROD_W-1:RPM_W-1] != '0) ? RPM_MAX : $signed(prod_q[RPM_W-1:0]);
    end
  end

  assign acc_sum = acc_q + (COEF_OLD[step_i] ? $signed({sf_q[SF_W-1], sf_q}) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      sf_q   <= '0;
      req_q  <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        req_q <= req_i;
        if (req_i) begin
          last_q <= count_i;
        end
      end
      if (ctrl_i.commit && req_q) begin
        sf_q <= acc_q[SF_W-1:0] + p2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      neg_q  <= diff_fix[CNT_W];
      mag_q  <= diff_fix[CNT_W] ? CNT_W'(-diff_fix) : diff_fix[CNT_W-1:0];
      prod_q <= '0;
    end
    // MSB-first shift-add over the scale constant
    if (ctrl_i.mul_step) begin
      prod_q <= {prod_q[PROD_W-2:0], 1'b0} + (SCALE_V[scale_idx] ? PROD_W'(mag_q) : '0);
    end
    if (ctrl_i.sat) begin
      acc_q <= '0;
      p2_q  <= '0;
      rsh_q <= SF_W'(rpm_v);
    end
    // LSB-first: halving each step keeps floor(0.6 * sf) exact
    if (ctrl_i.iir_step) begin
      acc_q <= acc_sum >>> 1;
      p2_q  <= p2_q + (COEF_NEW[step_i] ? rsh_q : '0);
      rsh_q <= rsh_q <<< 1;
    end
  end

  // Q16.16 to integer, truncated toward zero
  assign rotor_rpm_o = (sf_q[SF_W-1] && (sf_q[CNT_W-1:0] != '0)) ?
                       sf_q[SF_W-1:CNT_W] + RPM_W'(1) : sf_q[SF_W-1:CNT_W];

endmodule

// File: sv/quadrature_angle_speed_estimator.sv
// Channel  Dir  Width  Contents
// in_i     in   17     req_type, count
// out_o    out  48     mech_pos, elec_pos, rotor_rpm
// cfg      in   18     cfg_idx_i, cfg_wdata_i, strobed by cfg_we_i
//
// From accept to the next accept, one word passes through 16 modulo steps,
// 1 sign fix, 16 divide steps of the shared compare/subtract unit and 7
// shift-add steps for the pole pair multiply, plus accept and output load.
// in_i.ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next accept, only the next output load.
// Reset (async, active low) resets config (pole pairs to 1), clears tick count and filter state.
// Top level: angle path and sequencer. Depends on qase_pkg, qase_if, qase_speed.
module quadrature_angle_speed_estimator #(
  parameter int unsigned COUNTS_PER_REV = qase_pkg::CPR_DEF,
  parameter int unsigned TICK_RPM_SCALE = qase_pkg::SCALE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  qase_in_if.sink                           in_i,
  qase_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [qase_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qase_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import qase_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ELEC = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [CNT_W:0]      CPR_V     = (CNT_W+1)'(COUNTS_PER_REV);
  localparam logic [STEP_W-1:0]   STEP_LAST = STEP_W'(CNT_W - 1);
  localparam logic [STEP_W-1:0]   PP_LAST   = STEP_W'(PP_W - 1);

  logic [2:0]               state_q, state_d;
  logic [STEP_W-1:0]        step_q;
  logic [CNT_W-1:0]         zero_off_q;
  logic                     rev_q;
  logic [PP_W-1:0]          pp_q;
  logic [CNT_W-1:0]         sh_q;
  logic [CNT_W-1:0]         r_q;
  logic                     neg_q;
  logic [CNT_W-1:0]         elec_q;
  logic                     out_valid_q;
  logic [CNT_W-1:0]         out_mech_q;
  logic [CNT_W-1:0]         out_elec_q;
  logic signed [RPM_W-1:0]  out_spd_q;

  logic                     in_acc;
  logic                     out_free;
  logic                     step_end;
  logic signed [CNT_W:0]    delta_raw;
  logic signed [CNT_W:0]    delta;
  logic                     red_bit;
  logic [CNT_W:0]           red_t;
  logic                     red_ge;
  logic [CNT_W-1:0]         red_r;
  logic [STEP_W-1:0]        pp_idx;
  logic signed [RPM_W-1:0]  rotor_rpm;
  qase_ctrl_t               spd_ctrl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    delta_raw = $signed({1'b0, in_i.count}) - $signed({1'b0, zero_off_q});
    delta     = rev_q ? -delta_raw : delta_raw;
  end

  // shared restoring step: modulo while shifting the count in, then divide
  assign red_bit = (state_q == S_MOD) ? sh_q[CNT_W-1] : 1'b0;
  assign red_t   = {r_q, red_bit};
  assign red_ge  = (red_t >= CPR_V);
  assign red_r   = red_ge ? CNT_W'(red_t - CPR_V) : red_t[CNT_W-1:0];

  assign pp_idx   = PP_LAST - step_q;
  assign step_end = (state_q == S_ELEC) ? (step_q == PP_LAST) : (step_q == STEP_LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_MOD;
      S_MOD:  if (step_end) state_d = S_FIX;
      S_FIX:  state_d = S_DIV;
      S_DIV:  if (step_end) state_d = S_ELEC;
      S_ELEC: if (step_end) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    spd_ctrl.load     = in_acc;
    spd_ctrl.mul_step = (state_q == S_MOD);
    spd_ctrl.sat      = (state_q == S_FIX);
    spd_ctrl.iir_step = (state_q == S_DIV);
    spd_ctrl.commit   = (state_q == S_ELEC) && (step_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      zero_off_q  <= '0;
      rev_q       <= 1'b0;
      pp_q        <= POLE_PAIRS_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE || state_d != state_q) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ZERO_OFFSET: zero_off_q <= cfg_wdata_i[CNT_W-1:0];
          REG_REVERSE_DIR: rev_q      <= cfg_wdata_i[0];
          REG_POLE_PAIRS:  pp_q       <= cfg_wdata_i[PP_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_q <= delta[CNT_W];
          sh_q  <= delta[CNT_W] ? CNT_W'(-delta) : delta[CNT_W-1:0];
          r_q   <= '0;
        end
      end
      S_MOD: begin
        sh_q <= {sh_q[CNT_W-2:0], 1'b0};
        r_q  <= red_r;
      end
      S_FIX: begin
        if (neg_q && r_q != '0) begin
          r_q <= CPR_V[CNT_W-1:0] - r_q;
        end
      end
      S_DIV: begin
        // quotient bits land in sh_q, which then holds the mechanical angle
        r_q    <= red_r;
        sh_q   <= {sh_q[CNT_W-2:0], red_ge};
        elec_q <= '0;
      end
      S_ELEC: begin
        elec_q <= {elec_q[CNT_W-2:0], 1'b0} + (pp_q[pp_idx[$clog2(PP_W)-1:0]] ? sh_q : '0);
      end
      S_FIN: begin
        if (out_free) begin
          out_mech_q <= sh_q;
          out_elec_q <= elec_q;
          out_spd_q  <= rotor_rpm;
        end
      end
      default: ;
    endcase
  end

  qase_speed #(
    .COUNTS_PER_REV(COUNTS_PER_REV),
    .TICK_RPM_SCALE(TICK_RPM_SCALE)
  ) u_speed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (spd_ctrl),
    .step_i     (step_q),
    .req_i      (in_i.req_type),
    .count_i    (in_i.count),
    .rotor_rpm_o(rotor_rpm)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.mech_pos  = out_mech_q;
  assign out_o.elec_pos  = out_elec_q;
  assign out_o.rotor_rpm = out_spd_q;

endmodule

// File: sv/qase_checker.sv
// Port-level checks for the angle and speed estimator, bound to the top level.
// Depends on qase_pkg and quadrature_angle_speed_estimator.
module qase_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [qase_pkg::CNT_W-1:0]        mech_pos_i,
  input logic [qase_pkg::CNT_W-1:0]        elec_pos_i,
  input logic signed [qase_pkg::RPM_W-1:0] rotor_rpm_i
);
  import qase_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // one word at a time in the serial datapath
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted while serial datapath busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !(out_valid_i && !$past(out_valid_i)))
    else $error("result appeared right after accept");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && mech_pos_i == '0) |-> (elec_pos_i == '0))
    else $error("nonzero electrical angle at zero mechanical angle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(mech_pos_i) && $stable(elec_pos_i)
       && $stable(rotor_rpm_i)))
    else $error("stalled result word changed");

endmodule

bind quadrature_angle_speed_estimator qase_checker u_qase_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .mech_pos_i  (out_o.mech_pos),
  .elec_pos_i  (out_o.elec_pos),
  .rotor_rpm_i (out_o.rotor_rpm)
);
